/* sv/bbr_pkg.sv */
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared constants, the command word and the divide-by-nine helper for the
// 3x3 box blur.
// ----------------------------------------------------------------------------
package bbr_pkg;

	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_MAX   = 2 ** CFG_W - 1;
	localparam int COORD_W   = 10;
	localparam int RGB_W     = 24;
	localparam int SUM_W     = 12;
	localparam int MUL_W     = 13;

	localparam int DEF_MAX_WIDTH      = 1024;
	localparam int DEF_MAX_HEIGHT     = 1024;
	localparam int FRAME_WIDTH_RESET  = 800;
	localparam int FRAME_HEIGHT_RESET = 600;
	localparam int QUEUE_DEPTH        = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [7:0]       ALPHA      = 8'hFF;
	localparam logic [MUL_W-1:0] DIV9_MUL   = 13'd7282;
	localparam int               DIV9_SHIFT = 16;

	// one classified beat handed from the front end to the back end
	typedef struct packed {
		logic               flush;
		logic               emit_a;
		logic               emit_b;
		logic               first_col;
		logic               cap;
		logic               done;
		logic [2:0]         cols_a;
		logic [2:0]         cols_b;
		logic [2:0]         rows;
		logic [RGB_W-1:0]   rgb;
		logic [COORD_W-1:0] ax;
		logic [COORD_W-1:0] bx;
		logic [COORD_W-1:0] oy;
	} cmd_t;

	// floor(s / 9) for s up to 9 * 255
	function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
		logic [SUM_W+MUL_W-1:0] p;
		p = (SUM_W+MUL_W)'(s) * (SUM_W+MUL_W)'(DIV9_MUL);
		return p[DIV9_SHIFT +: 8];
	endfunction

endpackage

/* sv/box_blur_3x3_rgb.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box blur over a raster stream of RGBA8888 pixels, divide by nine.
// ----------------------------------------------------------------------------
// Takes one pixel or flush beat per clock while the command queue has room.
// A pixel beat normally gives one result, the last pixel of a row gives two,
// and those two leave the output register one after the other; a four-entry
// command queue between front and back absorbs that extra result and output
// stalls. An accepted beat passes the queue, stage 1, stage 2, stage 3 and
// the output register on its way to its first result. Each line store is a
// single memory of 2**$clog2(MAX_WIDTH) x 24 bits with one write and one
// registered read per cycle; it has no clearing pass. Writing a register
// restarts the frame.
module box_blur_3x3_rgb #(
	parameter int MAX_WIDTH  = bbr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bbr_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  logic                          mode,
	input  logic [31:0]                   pixel_in,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [31:0]                   pixel_out,
	output logic [bbr_pkg::COORD_W-1:0]   out_x,
	output logic [bbr_pkg::COORD_W-1:0]   out_y,
	output logic                          frame_done,
	output logic                          last_of_item,
	input  logic                          cfg_wen,
	input  logic [bbr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbr_pkg::CFG_W-1:0]     cfg_data
);

	localparam int FW = bbr_pkg::CFG_W;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int QW = $bits(bbr_pkg::cmd_t) + XW;
	localparam int CMD_W = $bits(bbr_pkg::cmd_t);

	localparam logic [FW-1:0] W_CAP =
		FW'((MAX_WIDTH > bbr_pkg::CFG_MAX) ? bbr_pkg::CFG_MAX : MAX_WIDTH);
	localparam logic [FW-1:0] H_CAP =
		FW'((MAX_HEIGHT > bbr_pkg::CFG_MAX) ? bbr_pkg::CFG_MAX : MAX_HEIGHT);
	localparam logic [FW-1:0] W_RESET =
		(FW'(bbr_pkg::FRAME_WIDTH_RESET) > W_CAP) ? W_CAP : FW'(bbr_pkg::FRAME_WIDTH_RESET);
	localparam logic [FW-1:0] H_RESET =
		(FW'(bbr_pkg::FRAME_HEIGHT_RESET) > H_CAP) ? H_CAP : FW'(bbr_pkg::FRAME_HEIGHT_RESET);

	logic [FW-1:0] frame_w_q, frame_h_q, cfg_val;

	logic          f_push, q_full, q_valid, q_pop;
	bbr_pkg::cmd_t f_cmd, q_cmd;
	logic [XW-1:0] f_addr, q_addr;
	logic [QW-1:0] q_wdata, q_rdata;

	assign cfg_val = (cfg_data == '0) ? FW'(1) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= W_RESET;
			frame_h_q <= H_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				bbr_pkg::REG_FRAME_WIDTH: begin
					frame_w_q <= (cfg_val > W_CAP) ? W_CAP : cfg_val;
				end
				bbr_pkg::REG_FRAME_HEIGHT: begin
					frame_h_q <= (cfg_val > H_CAP) ? H_CAP : cfg_val;
				end
				default: begin
					frame_w_q <= frame_w_q;
				end
			endcase
		end
	end

	bbr_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_wen),
		.frame_w   (frame_w_q),
		.frame_h   (frame_h_q),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.mode      (mode),
		.pixel_in  (pixel_in),
		.q_full    (q_full),
		.push      (f_push),
		.cmd       (f_cmd),
		.addr      (f_addr)
	);

	assign q_wdata = {f_addr, f_cmd};
	assign q_cmd   = bbr_pkg::cmd_t'(q_rdata[CMD_W-1:0]);
	assign q_addr  = q_rdata[QW-1 -: XW];

	bbr_queue #(
		.W     (QW),
		.DEPTH (bbr_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	bbr_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_addr       (q_addr),
		.q_pop        (q_pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.pixel_out    (pixel_out),
		.out_x        (out_x),
		.out_y        (out_y),
		.frame_done   (frame_done),
		.last_of_item (last_of_item)
	);

endmodule

/* sv/bbr_front.sv */
// ----------------------------------------------------------------------------
// bbr_front
// Accepts pixel and flush beats, tracks the raster position and turns each
// useful beat into a command for the back end.
// ----------------------------------------------------------------------------
module bbr_front #(
	parameter int MAX_WIDTH  = bbr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bbr_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic [bbr_pkg::CFG_W-1:0]     frame_w,
	input  logic [bbr_pkg::CFG_W-1:0]     frame_h,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  logic                          mode,
	input  logic [31:0]                   pixel_in,
	input  logic                          q_full,
	output logic                          push,
	output bbr_pkg::cmd_t                 cmd,
	output logic [$clog2(MAX_WIDTH)-1:0]  addr
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int CW = (XW + 1 > bbr_pkg::CFG_W) ? XW + 1 : bbr_pkg::CFG_W;
	localparam int RW = (YW + 1 > bbr_pkg::CFG_W) ? YW + 1 : bbr_pkg::CFG_W;
	localparam int OW = bbr_pkg::COORD_W;

	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic          flush_q;

	logic [CW-1:0] x_e, w_e;
	logic [RW-1:0] y_e, h_e;
	logic          last_col, last_row, is_pix, is_flush, accept;

	assign x_e = CW'(col_q);
	assign w_e = CW'(frame_w);
	assign y_e = RW'(row_q);
	assign h_e = RW'(frame_h);

	assign last_col = (x_e + CW'(1)) >= w_e;
	assign last_row = (y_e + RW'(1)) >= h_e;

	assign pix_stall = q_full;
	assign accept    = pix_valid && !q_full;
	assign is_pix    = !mode && !flush_q;
	assign is_flush  = mode && flush_q;
	assign push      = accept && (is_pix || is_flush);
	assign addr      = flush_q ? XW'(x_e + CW'(1)) : col_q;

	always_comb begin
		cmd     = '0;
		cmd.rgb = pixel_in[31:8];
		if (flush_q) begin
			cmd.flush     = 1'b1;
			cmd.emit_a    = 1'b1;
			cmd.first_col = (col_q == '0);
			cmd.done      = last_col;
			cmd.cols_a    = {!last_col, 1'b1, col_q != '0};
			cmd.rows      = {1'b0, 1'b1, h_e >= RW'(2)};
			cmd.ax        = OW'(x_e);
			cmd.bx        = OW'(x_e);
			cmd.oy        = OW'(h_e - RW'(1));
		end else begin
			cmd.emit_a = (row_q != '0) && (col_q != '0);
			cmd.emit_b = (row_q != '0) && last_col;
			cmd.cap    = last_row && (col_q == '0);
			cmd.cols_a = {1'b1, 1'b1, x_e >= CW'(2)};
			cmd.cols_b = {1'b1, col_q != '0, 1'b0};
			cmd.rows   = {1'b1, 1'b1, y_e >= RW'(2)};
			cmd.ax     = OW'(x_e - CW'(1));
			cmd.bx     = OW'(w_e - CW'(1));
			cmd.oy     = OW'(y_e - RW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			flush_q <= 1'b0;
		end else if (restart) begin
			col_q   <= '0;
			row_q   <= '0;
			flush_q <= 1'b0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				if (flush_q) begin
					flush_q <= 1'b0;
				end else if (last_row) begin
					row_q   <= '0;
					flush_q <= 1'b1;
				end else begin
					row_q <= YW'(y_e + RW'(1));
				end
			end else begin
				col_q <= XW'(x_e + CW'(1));
			end
		end
	end

endmodule

/* sv/bbr_queue.sv */
// ----------------------------------------------------------------------------
// bbr_queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bbr_queue #(
	parameter int W     = 8,
	parameter int DEPTH = bbr_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         full,
	output logic         valid,
	output logic [W-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full  = (count_q == NW'(DEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");

endmodule

/* sv/bbr_back.sv */
// ----------------------------------------------------------------------------
// bbr_back
// Line stores, 3x3 window, channel sums and divide by nine; emits up to two
// result beats per command through an output register.
// ----------------------------------------------------------------------------
module bbr_back #(
	parameter int MAX_WIDTH = bbr_pkg::DEF_MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  bbr_pkg::cmd_t                 q_cmd,
	input  logic [$clog2(MAX_WIDTH)-1:0]  q_addr,
	output logic                          q_pop,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [31:0]                   pixel_out,
	output logic [bbr_pkg::COORD_W-1:0]   out_x,
	output logic [bbr_pkg::COORD_W-1:0]   out_y,
	output logic                          frame_done,
	output logic                          last_of_item
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int CW = bbr_pkg::RGB_W;
	localparam int SW = bbr_pkg::SUM_W;

	logic [CW-1:0] line_above_q [2**XW];
	logic [CW-1:0] line_two_q   [2**XW];

	// stage 1: command with line store read data
	logic          valid_s1;
	bbr_pkg::cmd_t cmd_s1;
	logic [XW-1:0] addr_s1;
	logic [CW-1:0] rd_above_s1, rd_two_s1, fwd_above_s1, fwd_two_s1;
	logic          fwd_s1;

	// stage 2: window holds this command's neighborhood
	logic               valid_s2;
	bbr_pkg::cmd_t      cmd_s2;
	logic [2:0][2:0][CW-1:0] win_q;
	logic [2:0][CW-1:0] cap_q;

	// stage 3: channel sums
	logic               valid_s3;
	bbr_pkg::cmd_t      cmd_s3;
	logic [2:0][SW-1:0] sum_a_s3, sum_b_s3;
	logic               sent_a_q;

	logic                        out_valid_q, frame_done_q, last_q;
	logic [31:0]                 pixel_q;
	logic [bbr_pkg::COORD_W-1:0] x_q, y_q;

	logic [CW-1:0]      above_rd, two_rd;
	logic               out_free, cur_a, cur_last, emit;
	logic               ready_s3, ready_s2, adv_s2, adv_s1, wr_en;
	logic [2:0][SW-1:0] sum_a, sum_b, sel;
	logic [2:0][2:0][SW-1:0] col_sum;

	assign above_rd = fwd_s1 ? fwd_above_s1 : rd_above_s1;
	assign two_rd   = fwd_s1 ? fwd_two_s1 : rd_two_s1;

	assign out_free = !out_valid_q || !res_stall;
	assign cur_a    = cmd_s3.emit_a && !sent_a_q;
	assign cur_last = !cur_a || !cmd_s3.emit_b;
	assign emit     = valid_s3 && out_free;
	assign ready_s3 = !valid_s3 || (out_free && cur_last);
	assign ready_s2 = !valid_s2 || ready_s3;
	assign adv_s2   = valid_s2 && ready_s3;
	assign adv_s1   = valid_s1 && ready_s2;
	assign q_pop    = q_valid && (!valid_s1 || ready_s2);
	assign wr_en    = adv_s1 && !cmd_s1.flush;

	// line stores, registered read with bypass of the write in the same cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_above_q[addr_s1] <= cmd_s1.rgb;
			line_two_q[addr_s1]   <= above_rd;
		end
		if (q_pop) begin
			rd_above_s1  <= line_above_q[q_addr];
			rd_two_s1    <= line_two_q[q_addr];
			fwd_s1       <= wr_en && (addr_s1 == q_addr);
			fwd_above_s1 <= cmd_s1.rgb;
			fwd_two_s1   <= above_rd;
			cmd_s1       <= q_cmd;
			addr_s1      <= q_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cmd_s2   <= cmd_s1;
			win_q[0] <= win_q[1];
			if (cmd_s1.flush) begin
				win_q[1] <= cmd_s1.first_col ? cap_q : win_q[2];
				win_q[2] <= {CW'(0), above_rd, two_rd};
			end else begin
				win_q[1] <= win_q[2];
				win_q[2] <= {cmd_s1.rgb, above_rd, two_rd};
				if (cmd_s1.cap) begin
					cap_q <= {CW'(0), cmd_s1.rgb, above_rd};
				end
			end
		end
	end

	// column sums first, then the selected columns
	always_comb begin
		col_sum = '0;
		sum_a   = '0;
		sum_b   = '0;
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 3; k++) begin
				for (int r = 0; r < 3; r++) begin
					if (cmd_s2.rows[r]) begin
						col_sum[c][k] = col_sum[c][k] + SW'(win_q[c][r][k*8 +: 8]);
					end
				end
				if (cmd_s2.cols_a[c]) begin
					sum_a[k] = sum_a[k] + col_sum[c][k];
				end
				if (cmd_s2.cols_b[c]) begin
					sum_b[k] = sum_b[k] + col_sum[c][k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			cmd_s3   <= cmd_s2;
			sum_a_s3 <= sum_a;
			sum_b_s3 <= sum_b;
		end
	end

	assign sel = cur_a ? sum_a_s3 : sum_b_s3;

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_q      <= {bbr_pkg::div9(sel[2]), bbr_pkg::div9(sel[1]),
				bbr_pkg::div9(sel[0]), bbr_pkg::ALPHA};
			x_q          <= cur_a ? cmd_s3.ax : cmd_s3.bx;
			y_q          <= cmd_s3.oy;
			frame_done_q <= cur_a && cmd_s3.done;
			last_q       <= cur_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			sent_a_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= cmd_s1.emit_a || cmd_s1.emit_b;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s3 <= 1'b1;
			end else if (emit && cur_last) begin
				valid_s3 <= 1'b0;
			end
			if (adv_s2) begin
				sent_a_q <= 1'b0;
			end else if (emit && cur_a) begin
				sent_a_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid    = out_valid_q;
	assign pixel_out    = pixel_q;
	assign out_x        = x_q;
	assign out_y        = y_q;
	assign frame_done   = frame_done_q;
	assign last_of_item = last_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_done_q |-> last_q)
		else $error("frame done on a beat that is not last of its item");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_stall && !last_q |=> out_valid_q)
		else $error("second result of an item did not follow");

	a_s3_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (cmd_s3.emit_a || cmd_s3.emit_b))
		else $error("sum stage holds a command without results");

endmodule

/* tb/box_blur_3x3_rgb_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_chk
// Watches the pixel, result and register ports of the 3x3 box blur. It keeps
// its own line stores, window and position counters, works out the blurred
// pixels each accepted beat must produce and checks every result beat field
// by field against the oldest one still owed.
// ----------------------------------------------------------------------------
package box_blur_tb_pkg;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

endpackage

module box_blur_3x3_rgb_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	input  logic                          pix_stall,
	input  logic                          mode,
	input  logic [31:0]                   pixel_in,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  logic [31:0]                   pixel_out,
	input  logic [bbr_pkg::COORD_W-1:0]   out_x,
	input  logic [bbr_pkg::COORD_W-1:0]   out_y,
	input  logic                          frame_done,
	input  logic                          last_of_item,
	input  logic                          cfg_wen,
	input  logic [bbr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbr_pkg::CFG_W-1:0]     cfg_data,
	output int                            errors,
	output int                            pending,
	output int                            checked
);

	localparam int LINE_DEPTH = bbr_pkg::DEF_MAX_WIDTH;
	localparam int OW         = bbr_pkg::COORD_W;
	localparam int SW         = bbr_pkg::SUM_W;
	localparam int PW         = bbr_pkg::RGB_W;

	typedef struct packed {
		logic [31:0]   pix;
		logic [OW-1:0] x;
		logic [OW-1:0] y;
		logic          done;
		logic          last;
	} blurred_t;

	typedef struct packed {
		logic [SW-1:0] r;
		logic [SW-1:0] g;
		logic [SW-1:0] b;
	} rgb_sum_t;

	blurred_t      blurred_q[$];
	logic [PW-1:0] row_prev[LINE_DEPTH];
	logic [PW-1:0] row_prev2[LINE_DEPTH];
	logic [PW-1:0] win[9];
	int            frame_w;
	int            frame_h;
	int            col;
	int            row;
	int            flush_col;
	bit            draining;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic rgb_sum_t add_px(rgb_sum_t s, logic [PW-1:0] v);
		s.r = s.r + SW'(v[23:16]);
		s.g = s.g + SW'(v[15:8]);
		s.b = s.b + SW'(v[7:0]);
		return s;
	endfunction

	function automatic logic [31:0] pack_avg(rgb_sum_t s);
		return {8'(s.r / 9), 8'(s.g / 9), 8'(s.b / 9), bbr_pkg::ALPHA};
	endfunction

	// window columns c0..2, top row only once two rows lie above
	function automatic logic [31:0] window_avg(int c0, bit with_top);
		rgb_sum_t s;
		s = '0;
		for (int c = c0; c <= 2; c++) begin
			if (with_top)
				s = add_px(s, win[c * 3]);
			s = add_px(s, win[c * 3 + 1]);
			s = add_px(s, win[c * 3 + 2]);
		end
		return pack_avg(s);
	endfunction

	task automatic push_result(input logic [31:0] pix, input int x, input int y,
			input logic done, input logic last);
		blurred_t e;
		e.pix  = pix;
		e.x    = OW'(x);
		e.y    = OW'(y);
		e.done = done;
		e.last = last;
		blurred_q.push_back(e);
	endtask

	task automatic restart_frame();
		col       = 0;
		row       = 0;
		flush_col = 0;
		draining  = 1'b0;
		for (int i = 0; i < 9; i++)
			win[i] = '0;
	endtask

	task automatic set_reg(input logic [bbr_pkg::CFG_IDX_W-1:0] idx,
			input logic [bbr_pkg::CFG_W-1:0] v);
		int val;
		val = (v == 0) ? 1 : int'(v);
		if (idx == bbr_pkg::REG_FRAME_WIDTH)
			frame_w = (val > bbr_pkg::DEF_MAX_WIDTH) ? bbr_pkg::DEF_MAX_WIDTH : val;
		else if (idx == bbr_pkg::REG_FRAME_HEIGHT)
			frame_h = (val > bbr_pkg::DEF_MAX_HEIGHT) ? bbr_pkg::DEF_MAX_HEIGHT : val;
		restart_frame();
	endtask

	task automatic blur_pixel(input logic [31:0] p);
		int x;
		int y;
		bit emit_a;
		bit emit_b;
		x = col;
		y = row;
		if (!draining) begin
			for (int i = 0; i < 6; i++)
				win[i] = win[i + 3];
			win[6]       = row_prev2[x];
			win[7]       = row_prev[x];
			win[8]       = p[31:8];
			row_prev2[x] = row_prev[x];
			row_prev[x]  = p[31:8];

			emit_a = (y >= 1) && (x >= 1);
			emit_b = (y >= 1) && (x + 1 == frame_w);
			if (emit_a)
				push_result(window_avg((x >= 2) ? 0 : 1, y >= 2), x - 1, y - 1, 1'b0, !emit_b);
			if (emit_b)
				push_result(window_avg((x >= 1) ? 1 : 2, y >= 2), frame_w - 1, y - 1, 1'b0, 1'b1);

			if (x + 1 >= frame_w) begin
				col = 0;
				if (y + 1 >= frame_h) begin
					row       = 0;
					draining  = 1'b1;
					flush_col = 0;
				end else begin
					row = y + 1;
				end
			end else begin
				col = x + 1;
			end
		end
	endtask

	task automatic blur_flush();
		int cx;
		logic done;
		rgb_sum_t s;
		if (draining) begin
			s = '0;
			for (int d = -1; d <= 1; d++) begin
				cx = flush_col + d;
				if (cx >= 0 && cx < frame_w) begin
					if (frame_h >= 2)
						s = add_px(s, row_prev2[cx]);
					s = add_px(s, row_prev[cx]);
				end
			end
			done = (flush_col + 1 >= frame_w);
			push_result(pack_avg(s), flush_col, frame_h - 1, done, 1'b1);
			if (done) begin
				draining  = 1'b0;
				flush_col = 0;
			end else begin
				flush_col++;
			end
		end
	endtask

	task automatic check_result();
		blurred_t e;
		if (blurred_q.size() == 0) begin
			report_mismatch($sformatf("result with nothing owed: %h at (%0d,%0d)",
				pixel_out, out_x, out_y));
		end else begin
			e = blurred_q.pop_front();
			checked++;
			if (pixel_out !== e.pix)
				report_mismatch($sformatf("pixel_out at (%0d,%0d): got %h want %h",
					e.x, e.y, pixel_out, e.pix));
			if (out_x !== e.x)
				report_mismatch($sformatf("out_x: got %0d want %0d", out_x, e.x));
			if (out_y !== e.y)
				report_mismatch($sformatf("out_y: got %0d want %0d", out_y, e.y));
			if (frame_done !== e.done)
				report_mismatch($sformatf("frame_done at (%0d,%0d): got %b want %b",
					e.x, e.y, frame_done, e.done));
			if (last_of_item !== e.last)
				report_mismatch($sformatf("last_of_item at (%0d,%0d): got %b want %b",
					e.x, e.y, last_of_item, e.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blurred_q.delete();
			for (int i = 0; i < LINE_DEPTH; i++) begin
				row_prev[i]  = '0;
				row_prev2[i] = '0;
			end
			frame_w = bbr_pkg::FRAME_WIDTH_RESET;
			frame_h = bbr_pkg::FRAME_HEIGHT_RESET;
			restart_frame();
			errors  = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (res_valid && !res_stall)
				check_result();
			if (cfg_wen)
				set_reg(cfg_index, cfg_data);
			if (pix_valid && !pix_stall) begin
				if (mode == box_blur_tb_pkg::MODE_FLUSH)
					blur_flush();
				else
					blur_pixel(pixel_in);
			end
			pending = blurred_q.size();
		end
	end

endmodule

/* tb/box_blur_3x3_rgb_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_tb
// Streams frames of pixels and flush beats into the 3x3 box blur: a short
// directed start on tiny frames and extreme pixel values, then random frame
// sizes with random content, stray beats and cut-off frames, then the first
// beats of the widest and the tallest frame. Sender gaps and result stalls
// vary by phase.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_tb;

	localparam int RANDOM_ITEMS  = 980;
	localparam int CLAMP_BEATS   = 30;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 12;
	localparam int FW            = bbr_pkg::CFG_W;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          pix_valid = 1'b0;
	logic                          pix_stall;
	logic                          mode = box_blur_tb_pkg::MODE_PIXEL;
	logic [31:0]                   pixel_in = '0;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	logic [31:0]                   pixel_out;
	logic [bbr_pkg::COORD_W-1:0]   out_x;
	logic [bbr_pkg::COORD_W-1:0]   out_y;
	logic                          frame_done;
	logic                          last_of_item;
	logic                          cfg_wen = 1'b0;
	logic [bbr_pkg::CFG_IDX_W-1:0] cfg_index = bbr_pkg::REG_FRAME_WIDTH;
	logic [FW-1:0]                 cfg_data = '0;

	int errors;
	int pending;
	int checked;
	int gap_pct   = 0;
	int stall_pct = 0;
	int beats     = 0;
	int settings  = 0;
	int cycles    = 0;

	box_blur_3x3_rgb u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.mode        (mode),
		.pixel_in    (pixel_in),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.pixel_out   (pixel_out),
		.out_x       (out_x),
		.out_y       (out_y),
		.frame_done  (frame_done),
		.last_of_item(last_of_item),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	box_blur_3x3_rgb_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.mode        (mode),
		.pixel_in    (pixel_in),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.pixel_out   (pixel_out),
		.out_x       (out_x),
		.out_y       (out_y),
		.frame_done  (frame_done),
		.last_of_item(last_of_item),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending),
		.checked     (checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, pending);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic int eff_size(input int v, input int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic logic [31:0] rand_pixel();
		case ($urandom_range(7))
			0: return '1;
			1: return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_beat(input logic m, input logic [31:0] p);
		while ($urandom_range(99) < gap_pct) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		mode      <= m;
		pixel_in  <= p;
		do @(posedge clk); while (pix_stall);
		@(negedge clk);
	endtask

	task automatic settle();
		pix_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [bbr_pkg::CFG_IDX_W-1:0] idx, input int val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= FW'(val);
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_frame(input int w, input int h, input int phase);
		settle();
		case (phase % 4)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 51; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 51; end
			default: begin gap_pct = 27; stall_pct = 27; end
		endcase
		write_reg(bbr_pkg::REG_FRAME_WIDTH, w);
		write_reg(bbr_pkg::REG_FRAME_HEIGHT, h);
		settings++;
	endtask

	// cut < 0 runs the whole frame and its drain, else stop after cut beats
	task automatic run_frame(input int w, input int h, input int cut);
		int sent;
		sent = 0;
		for (int i = 0; i < w * h && sent != cut; i++) begin
			if ($urandom_range(19) == 0)
				send_beat(box_blur_tb_pkg::MODE_FLUSH, rand_pixel());
			send_beat(box_blur_tb_pkg::MODE_PIXEL, rand_pixel());
			sent++;
			beats++;
		end
		for (int i = 0; i < w && sent != cut; i++) begin
			if ($urandom_range(19) == 0)
				send_beat(box_blur_tb_pkg::MODE_PIXEL, rand_pixel());
			send_beat(box_blur_tb_pkg::MODE_FLUSH, $urandom);
			sent++;
			beats++;
		end
	endtask

	initial begin
		int w;
		int h;
		int cut;
		int cur_w;
		int cur_h;
		int rand_start;
		int pick;
		bit fresh;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 3x3 frame with saturated, empty and mixed pixels
		set_frame(3, 3, 0);
		send_beat(box_blur_tb_pkg::MODE_FLUSH, '0);
		for (int i = 0; i < 9; i++) begin
			case (i % 3)
				0: send_beat(box_blur_tb_pkg::MODE_PIXEL, '1);
				1: send_beat(box_blur_tb_pkg::MODE_PIXEL, '0);
				default: send_beat(box_blur_tb_pkg::MODE_PIXEL, 32'hA55A_C33C);
			endcase
			beats++;
		end
		send_beat(box_blur_tb_pkg::MODE_PIXEL, '1);
		for (int i = 0; i < 3; i++) begin
			send_beat(box_blur_tb_pkg::MODE_FLUSH, '0);
			beats++;
		end

		// zero sizes read as one
		set_frame(0, 0, 0);
		send_beat(box_blur_tb_pkg::MODE_PIXEL, '1);
		send_beat(box_blur_tb_pkg::MODE_FLUSH, '0);
		beats += 2;

		// single row, all results from the drain
		set_frame(2, 1, 0);
		run_frame(2, 1, -1);

		rand_start = beats;
		fresh      = 1'b1;
		cur_w      = 1;
		cur_h      = 1;
		while (beats - rand_start < RANDOM_ITEMS) begin
			pick = $urandom_range(19);
			if (pick < 14)
				w = $urandom_range(1, 8);
			else if (pick < 18)
				w = $urandom_range(9, 40);
			else
				w = 0;
			h = $urandom_range(0, 6);
			if (fresh || $urandom_range(4) != 0) begin
				set_frame(w, h, settings);
				cur_w = eff_size(w, bbr_pkg::DEF_MAX_WIDTH);
				cur_h = eff_size(h, bbr_pkg::DEF_MAX_HEIGHT);
			end
			cut = ($urandom_range(11) == 0) ? $urandom_range(0, cur_w * cur_h) : -1;
			run_frame(cur_w, cur_h, cut);
			fresh = (cut >= 0);
		end

		// oversized register values, first beats of the widest row and tallest column
		set_frame(bbr_pkg::CFG_MAX, 0, 0);
		run_frame(bbr_pkg::DEF_MAX_WIDTH, 1, CLAMP_BEATS);
		set_frame(1, bbr_pkg::CFG_MAX, 3);
		run_frame(1, bbr_pkg::DEF_MAX_HEIGHT, CLAMP_BEATS);

		settle();
		$display("%0d beats streamed over %0d frame settings, %0d blurred pixels checked",
			beats, settings, checked);
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
